[rtl/core/sha256_stream_hasher_macros.svh]
// Assertion macros for the SHA-256 stream hasher checker.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Checked on every rising clock edge once reset has been released.
`define SHS_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, also while reset is asserted.
`define SHS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/shs_pkg.sv]
// Constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

	localparam int DIGEST_WORDS = 8;
	localparam int BLOCK_WORDS  = 16;
	localparam int ROUNDS       = 64;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] initial_h(input logic [2:0] i);
		logic [31:0] h;
		case (i)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = 32'h00000000;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

[rtl/core/sha256_stream_hasher.sv]
// SHA-256 stream hasher: byte stream in, eight digest words out.
//
// Message bytes are taken one per cycle while the hasher is idle and packed into a 16-word
// block memory. When the 64th byte of a block is taken, input stalls while LOAD loads the
// working variables and starts the first block memory read, ROUND runs the 64 rounds, and
// UPDATE adds the result into the hash. On the last word the padding is written into the
// block memory one word per cycle, followed by one or two compressions and a DONE step
// that moves the digest into the output buffer. The digest leaves as eight words, word 0
// first, one per cycle when the receiver is ready, while the next message is already
// being taken.
module sha256_stream_hasher
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_ROUND  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_PAD    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [54:0] blk_cnt_q;
	logic [23:0] acc_q;
	logic [63:0] total_q;
	logic [3:0]  pad_idx_q;
	logic        pad_first_q;
	logic        pad_len_q;
	logic        pend_pad_q;
	logic        final_q;
	logic [5:0]  rnd_q;

	logic [31:0] hash_q [DIGEST_WORDS];
	logic [31:0] v_q    [DIGEST_WORDS];
	logic [31:0] win_q  [BLOCK_WORDS];
	logic [31:0] out_q  [DIGEST_WORDS];
	logic [3:0]  out_cnt_q;
	logic [2:0]  out_idx_q;

	logic [31:0] blk_mem [BLOCK_WORDS];
	logic [31:0] rd_word_q;

	logic        in_acc;
	logic        out_acc;
	logic        blk_full;
	logic [5:0]  fill_inc;
	logic [5:0]  fill_new;
	logic [54:0] blk_new;
	logic        mem_we;
	logic [3:0]  mem_wa;
	logic [31:0] mem_wd;
	logic [3:0]  mem_ra;
	logic [31:0] head_word;
	logic [31:0] pad_word;
	logic [31:0] sched_w;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	assign blk_full = s_axis_tuser && (fill_q == 6'd63);
	assign fill_inc = fill_q + 6'd1;
	assign fill_new = s_axis_tuser ? fill_inc : fill_q;
	assign blk_new  = blk_cnt_q + {54'd0, blk_full};

	always_comb begin
		case (fill_q[1:0])
			2'd0: head_word = {PAD_BYTE, 24'd0};
			2'd1: head_word = {acc_q[7:0], PAD_BYTE, 16'd0};
			2'd2: head_word = {acc_q[15:0], PAD_BYTE, 8'd0};
			2'd3: head_word = {acc_q, PAD_BYTE};
			default: head_word = 32'd0;
		endcase
		if (pad_len_q && pad_idx_q == 4'd14) begin
			pad_word = total_q[63:32];
		end else if (pad_len_q && pad_idx_q == 4'd15) begin
			pad_word = total_q[31:0];
		end else if (pad_first_q) begin
			pad_word = head_word;
		end else begin
			pad_word = 32'd0;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[5:2];
		mem_wd = {acc_q, s_axis_tdata};
		if (state_q == ST_PAD) begin
			mem_we = 1'b1;
			mem_wa = pad_idx_q;
			mem_wd = pad_word;
		end else if (in_acc && s_axis_tuser && fill_q[1:0] == 2'd3) begin
			mem_we = 1'b1;
		end
		mem_ra = (state_q == ST_ROUND) ? rnd_q[3:0] + 4'd1 : 4'd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[mem_wa] <= mem_wd;
		end
		rd_word_q <= blk_mem[mem_ra];
	end

	always_comb begin
		sched_w = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);
		w_cur   = rnd_q[5:4] == 2'd0 ? rd_word_q : sched_w;
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(rnd_q) + w_cur;
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= w_cur;
		end
		if (in_acc && s_axis_tuser) begin
			acc_q <= {acc_q[15:0], s_axis_tdata};
		end
		if (in_acc && s_axis_tlast) begin
			total_q <= {blk_new, fill_new, 3'b000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= 6'd0;
			blk_cnt_q   <= 55'd0;
			pad_idx_q   <= 4'd0;
			pad_first_q <= 1'b0;
			pad_len_q   <= 1'b0;
			pend_pad_q  <= 1'b0;
			final_q     <= 1'b0;
			rnd_q       <= 6'd0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				hash_q[i] <= initial_h(3'(i));
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fill_q    <= fill_new;
						blk_cnt_q <= blk_new;
						if (blk_full) begin
							state_q     <= ST_LOAD;
							pend_pad_q  <= s_axis_tlast;
							pad_idx_q   <= 4'd0;
							pad_first_q <= 1'b1;
							pad_len_q   <= 1'b1;
						end else if (s_axis_tlast) begin
							state_q     <= ST_PAD;
							pad_idx_q   <= fill_new[5:2];
							pad_first_q <= 1'b1;
							pad_len_q   <= (fill_new < 6'd56);
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (pad_idx_q == 4'd15) begin
						state_q    <= ST_LOAD;
						final_q    <= pad_len_q;
						pend_pad_q <= !pad_len_q;
						pad_idx_q  <= 4'd0;
						pad_len_q  <= 1'b1;
					end else begin
						pad_idx_q <= pad_idx_q + 4'd1;
					end
				end
				ST_LOAD: begin
					state_q <= ST_ROUND;
					rnd_q   <= 6'd0;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					for (int i = 0; i < DIGEST_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (final_q) begin
						state_q <= ST_DONE;
					end else if (pend_pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_cnt_q == 4'd0) begin
						state_q    <= ST_IDLE;
						fill_q     <= 6'd0;
						blk_cnt_q  <= 55'd0;
						final_q    <= 1'b0;
						pend_pad_q <= 1'b0;
						for (int i = 0; i < DIGEST_WORDS; i++) begin
							hash_q[i] <= initial_h(3'(i));
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_cnt_q == 4'd0) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				out_q[i] <= hash_q[i];
			end
		end else if (out_acc) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
				out_q[i] <= out_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 4'd0;
			out_idx_q <= 3'd0;
		end else if (state_q == ST_DONE && out_cnt_q == 4'd0) begin
			out_cnt_q <= 4'(DIGEST_WORDS);
			out_idx_q <= 3'd0;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - 4'd1;
			out_idx_q <= out_idx_q + 3'd1;
		end
	end

	assign m_axis_tvalid = (out_cnt_q != 4'd0);
	assign m_axis_tdata  = out_q[0];
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = (out_idx_q == 3'(DIGEST_WORDS - 1));

endmodule

[rtl/core/shs_checker.sv]
// Port-level checker for the SHA-256 stream hasher and its bind.
`include "sha256_stream_hasher_macros.svh"

module shs_checker
	import shs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,  // [7:0] byte_value
	input logic        s_axis_tuser,  // [0] has_byte
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,  // [31:0] digest_word
	input logic [2:0]  m_axis_tuser,  // [2:0] word_index
	input logic        m_axis_tlast
);

	`SHS_ASSERT_ALWAYS(a_no_word_in_reset, !arst_n |-> !m_axis_tvalid, "Digest word shown during reset.")
	`SHS_ASSERT_RST(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "Stalled digest word changed.")
	`SHS_ASSERT_RST(a_last_on_final, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'(DIGEST_WORDS - 1))), "Last flag not on the final digest word.")
	`SHS_ASSERT_RST(a_word_order, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1), "Digest words out of order.")
	`SHS_ASSERT_RST(a_stall_after_end, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "Input taken right after the end of a message.")

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the SHA-256 stream hasher: random byte streams against a digest predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int RANDOM_ITEMS   = 370;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [0:7][31:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       last_byte;
		int         gap;
		bit         hold;
	} byte_word_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] byte_value
	logic        s_axis_tuser = 1'b0;   // [0] has_byte
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [31:0] digest_word
	logic [2:0]  m_axis_tuser;          // [2:0] word_index
	logic        m_axis_tlast;

	byte_word_t   pending_bytes[$];
	digest_word_t expected_digest[$];

	logic [7:0]  msg_block [64];
	int          block_fill;
	logic [63:0] msg_bits;
	logic [31:0] chain_hash [8];

	int words_owed = 0;
	bit feeding_done = 1'b0;
	int idle_cycles = 0;
	int failures = 0;
	int gap_count = 0;
	int stall_left = 0;
	int calm_left = 0;

	sha256_stream_hasher uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void run_compression();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int r = 0; r < 64; r++) begin
			if (r < 16)
				sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
			else
				sched[r] = sched[r-16] + sched[r-7]
					+ (rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3))
					+ (rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10));
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain_hash[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_hash[i] = chain_hash[i] + v[i];
	endfunction

	function automatic void absorb_word(logic [7:0] value, logic has, logic last);
		logic [63:0] total;
		int idx;
		if (has) begin
			msg_block[block_fill] = value;
			block_fill++;
			if (block_fill == 64) begin
				run_compression();
				msg_bits = msg_bits + 64'd512;
				block_fill = 0;
			end
		end
		if (!last)
			return;
		total = msg_bits + (64'(block_fill) << 3);
		idx = block_fill;
		msg_block[idx] = PAD_MARK;
		idx++;
		if (idx > 56) begin
			while (idx < 64) begin
				msg_block[idx] = 8'h00;
				idx++;
			end
			run_compression();
			idx = 0;
		end
		while (idx < 56) begin
			msg_block[idx] = 8'h00;
			idx++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[63 - i] = total[8*i +: 8];
		run_compression();
		for (int i = 0; i < 8; i++)
			expected_digest.push_back('{chain_hash[i], 3'(i), i == 7});
		for (int i = 0; i < 8; i++)
			chain_hash[i] = H_INIT[i];
		block_fill = 0;
		msg_bits = 64'd0;
	endfunction

	function automatic void add_word(logic [7:0] value, logic has, logic last, int gap, bit hold);
		byte_word_t w;
		w.byte_value = value;
		w.has_byte = has;
		w.last_byte = last;
		w.gap = gap;
		w.hold = hold;
		pending_bytes.push_back(w);
	endfunction

	function automatic int add_message(int len, bit bare_end, bit calm, bit hold);
		int count;
		count = 0;
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 99) < 4) begin
				add_word(8'($urandom), 1'b0, 1'b0, calm ? 0 : pick_gap(), 1'b0);
				count++;
			end
			add_word(8'($urandom), 1'b1, !bare_end && n == len - 1, calm ? 0 : pick_gap(),
				hold && n == 0);
			count++;
		end
		if (bare_end || len == 0) begin
			add_word(8'($urandom), 1'b0, 1'b1, calm ? 0 : pick_gap(), hold && len == 0);
			count++;
		end
		return count;
	endfunction

	initial begin : stimulus
		int made;
		int len;
		int r;
		block_fill = 0;
		msg_bits = 64'd0;
		for (int i = 0; i < 8; i++)
			chain_hash[i] = H_INIT[i];

		add_word(8'h00, 1'b0, 1'b1, pick_gap(), 1'b0);
		add_word(8'hff, 1'b0, 1'b0, pick_gap(), 1'b0);
		add_word(8'hff, 1'b0, 1'b1, pick_gap(), 1'b0);
		add_word(8'h61, 1'b1, 1'b0, pick_gap(), 1'b0);
		add_word(8'h62, 1'b1, 1'b0, pick_gap(), 1'b0);
		add_word(8'h63, 1'b1, 1'b1, pick_gap(), 1'b0);
		add_word(8'h00, 1'b1, 1'b1, pick_gap(), 1'b0);
		add_word(8'hff, 1'b1, 1'b1, pick_gap(), 1'b0);
		add_word(8'ha5, 1'b1, 1'b0, pick_gap(), 1'b0);
		add_word(8'h5a, 1'b1, 1'b0, pick_gap(), 1'b0);
		add_word(8'h00, 1'b0, 1'b1, pick_gap(), 1'b0);
		add_word(8'h01, 1'b1, 1'b0, pick_gap(), 1'b1);
		add_word(8'hff, 1'b0, 1'b0, pick_gap(), 1'b0);
		add_word(8'h80, 1'b1, 1'b1, pick_gap(), 1'b0);
		add_word(8'h00, 1'b0, 1'b1, 0, 1'b1);

		// Lengths around the padding boundary come first, then random messages.
		made = 0;
		made += add_message(55, $urandom_range(0, 1), 1'b0, 1'b1);
		made += add_message(56, $urandom_range(0, 1), 1'b1, 1'b0);
		made += add_message(63, $urandom_range(0, 1), 1'b0, 1'b0);
		made += add_message(64, $urandom_range(0, 1), 1'b0, 1'b1);
		while (made < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				len = $urandom_range(0, 8);
			else if (r < 65)
				len = $urandom_range(9, 40);
			else if (r < 90)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(100, 130);
			if (len > RANDOM_ITEMS - made)
				len = RANDOM_ITEMS - made;
			made += add_message(len, $urandom_range(0, 99) < 35, $urandom_range(0, 99) < 30,
				$urandom_range(0, 99) < 15);
		end

		wait (arst_n);
		do
			@(posedge clk);
		while (!(feeding_done && words_owed == 0));
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		byte_word_t head;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			feeding_done <= 1'b0;
			gap_count = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				feeding_done <= 1'b1;
			end else if (gap_count < pending_bytes[0].gap) begin
				gap_count++;
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes[0].hold && (words_owed != 0 || (s_axis_tvalid && s_axis_tlast))) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				head = pending_bytes.pop_front();
				gap_count = 0;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= head.byte_value;
				s_axis_tuser <= head.has_byte;
				s_axis_tlast <= head.last_byte;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		digest_word_t want;
		bit in_taken;
		bit out_taken;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			words_owed <= 0;
			idle_cycles <= 0;
			stall_left = 0;
			calm_left = 0;
		end else begin
			in_taken = s_axis_tvalid && s_axis_tready;
			out_taken = m_axis_tvalid && m_axis_tready;
			if (out_taken) begin
				if (expected_digest.size() == 0) begin
					$error("digest_word: expected none, actual %08h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_digest.pop_front();
					if (m_axis_tdata !== want.digest_word) begin
						$error("digest_word: expected %08h, actual %08h", want.digest_word,
							m_axis_tdata);
						failures++;
					end
					if (m_axis_tuser !== want.word_index) begin
						$error("word_index: expected %0d, actual %0d", want.word_index,
							m_axis_tuser);
						failures++;
					end
					if (m_axis_tlast !== want.last_word) begin
						$error("last_word: expected %0b, actual %0b", want.last_word,
							m_axis_tlast);
						failures++;
					end
				end
			end
			if (in_taken)
				absorb_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			words_owed <= expected_digest.size();
			idle_cycles <= (in_taken || out_taken) ? 0 : idle_cycles + 1;

			// Stalls on the result side, with occasional calm stretches.
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 199) == 0)
				calm_left = $urandom_range(30, 150);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (calm_left == 0)
					stall_left = pick_gap();
				m_axis_tready <= (stall_left == 0);
			end
		end
	end

endmodule
